FILE: hw/rtl/scdd_pkg.sv
package scdd_pkg;

  // field widths
  localparam int unsigned SampleW = 10;
  localparam int unsigned SegW    = 8;
  localparam int unsigned SelW    = 7;
  localparam int unsigned PeriodW = 8;
  localparam int unsigned CodeW   = 4;

  // a 10-bit sample has at most four decimal digits
  localparam int unsigned LeadW = 2;
  localparam int unsigned LeadN = 1 << LeadW;

  localparam int unsigned DigitsDefault = 7;

  localparam logic [PeriodW-1:0] PeriodReset = 8'd25;
  localparam logic [CodeW-1:0]   BlankCode   = 4'hf;
  localparam logic [SegW-1:0]    SegBlankN   = 8'hff;

  // item command codes
  localparam logic CmdTick   = 1'b0;
  localparam logic CmdSample = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [SampleW-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [SegW-1:0] segments_n;
    logic [SelW-1:0] digit_select;
    logic            start_conversion;
  } result_t;

  // left-justified decimal digits, lead[0] is the leftmost position
  typedef struct packed {
    logic [LeadN-1:0][CodeW-1:0] lead;
  } dec_t;

  // active-low pattern, bit 0 = a .. bit 6 = g, bit 7 = dp (kept off)
  function automatic logic [SegW-1:0] seg_pattern(input logic [CodeW-1:0] code);
    logic [SegW-1:0] pat;
    case (code)
      4'd0:    pat = 8'h3f;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5b;
      4'd3:    pat = 8'h4f;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6d;
      4'd6:    pat = 8'h7d;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7f;
      4'd9:    pat = 8'h6f;
      default: pat = 8'h00;
    endcase
    return (code > 4'd9) ? SegBlankN : ~pat;
  endfunction

endpackage

FILE: hw/rtl/scdd_if.sv
interface scdd_in_if import scdd_pkg::*;;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [SampleW-1:0] sample;

  modport source (output valid, cmd, sample, input ready);
  modport sink   (input valid, cmd, sample, output ready);
endinterface

interface scdd_out_if import scdd_pkg::*;;
  logic            valid;
  logic            ready;
  logic [SegW-1:0] segments_n;
  logic [SelW-1:0] digit_select;
  logic            start_conversion;

  modport source (output valid, segments_n, digit_select, start_conversion, input ready);
  modport sink   (input valid, segments_n, digit_select, start_conversion, output ready);
endinterface

FILE: hw/rtl/scdd_bcd.sv
module scdd_bcd import scdd_pkg::*; (
  input  logic [SampleW-1:0] sample_i,
  output dec_t               dec_o
);

  // reciprocal multipliers, exact over the ranges used here
  localparam logic [5:0] RecipHund = 6'd41;   // r*41 >> 12 == r/100 for r < 1000
  localparam logic [6:0] RecipTen  = 7'd103;  // r*103 >> 10 == r/10 for r < 100

  logic             thou;
  logic [9:0]       rem_h;
  logic [15:0]      prod_h;
  logic [CodeW-1:0] hund;
  logic [9:0]       rem_t_w;
  logic [6:0]       rem_t;
  logic [13:0]      prod_t;
  logic [CodeW-1:0] tens;
  logic [6:0]       ones_w;
  logic [CodeW-1:0] ones;
  logic [CodeW-1:0] thou_c;

  always_comb begin
    thou    = (sample_i >= 10'd1000);
    thou_c  = {3'b000, thou};
    rem_h   = thou ? (sample_i - 10'd1000) : sample_i;
    prod_h  = 16'(rem_h) * 16'(RecipHund);
    hund    = prod_h[15:12];
    rem_t_w = rem_h - (10'(hund) * 10'd100);
    rem_t   = rem_t_w[6:0];
    prod_t  = 14'(rem_t) * 14'(RecipTen);
    tens    = prod_t[13:10];
    ones_w  = rem_t - (7'(tens) * 7'd10);
    ones    = ones_w[CodeW-1:0];

    // drop leading zeros, a zero value keeps a single digit
    if (thou) begin
      dec_o.lead = {ones, tens, hund, thou_c};
    end else if (hund != '0) begin
      dec_o.lead = {BlankCode, ones, tens, hund};
    end else if (tens != '0) begin
      dec_o.lead = {BlankCode, BlankCode, ones, tens};
    end else begin
      dec_o.lead = {BlankCode, BlankCode, BlankCode, ones};
    end
  end

endmodule

FILE: hw/rtl/scdd_core.sv
module scdd_core import scdd_pkg::*; #(
  parameter int unsigned DIGITS = DigitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PeriodW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  item_t              in_item_i,
  input  dec_t               dec_i,
  output logic               in_take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output result_t            out_res_o
);

  localparam int unsigned IdxW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DIGITS - 1);
  localparam int unsigned SelWideW = SelW + DIGITS;

  logic [PeriodW-1:0] period_q;
  logic [CodeW-1:0]   digit_q [DIGITS];
  logic [CodeW-1:0]   digit_d [DIGITS];
  logic [IdxW-1:0]    scan_q, scan_d;
  logic [PeriodW-1:0] count_q, count_d;
  logic               out_valid_q, out_valid_d;
  result_t            res_q, res_d;

  logic                take, tick_go, sample_go;
  logic [PeriodW:0]    cnt_inc;
  logic                start;
  logic [SelWideW-1:0] sel_wide;

  always_comb begin
    take      = in_valid_i && ((in_item_i.cmd == CmdSample) || !out_valid_q || out_ready_i);
    tick_go   = take && (in_item_i.cmd == CmdTick);
    sample_go = take && (in_item_i.cmd == CmdSample);

    cnt_inc  = {1'b0, count_q} + 1'b1;
    start    = (cnt_inc >= {1'b0, period_q});
    sel_wide = SelWideW'(1) << scan_q;

    res_d.segments_n       = seg_pattern(digit_q[scan_q]);
    res_d.digit_select     = sel_wide[SelW-1:0];
    res_d.start_conversion = start;

    scan_d  = scan_q;
    count_d = count_q;
    if (tick_go) begin
      scan_d  = (scan_q == LastIdx) ? '0 : scan_q + 1'b1;
      count_d = start ? '0 : cnt_inc[PeriodW-1:0];
    end

    for (int i = 0; i < DIGITS; i++) begin
      if (!sample_go) begin
        digit_d[i] = digit_q[i];
      end else if (i < LeadN) begin
        digit_d[i] = dec_i.lead[LeadW'(i)];
      end else begin
        digit_d[i] = BlankCode;
      end
    end

    if (tick_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PeriodReset;
      scan_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        digit_q[i] <= BlankCode;
      end
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      scan_q      <= scan_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < DIGITS; i++) begin
        digit_q[i] <= digit_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_go) begin
      res_q <= res_d;
    end
  end

  assign in_take_o   = take;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

FILE: hw/rtl/scanned_decimal_segment_display.sv
// Scanned decimal seven-segment display driver. Each input transfer is either a refresh
// tick (cmd 0) or a converter sample (cmd 1). A sample is split into decimal digits, stored
// left-justified without leading zeros, with the remaining positions blank; it gives no
// result. A tick drives the next position in turn: the active-low segments of its digit
// (decimal point off, blank shows all segments off), a one-hot digit select, and
// start_conversion on every conversion_period-th tick. One item is taken per clock cycle,
// tick or sample, but a tick waits while the last result is not taken. Each item is held
// in the input register; a tick then loads its result into the result register, a sample
// writes the digit store. The rate is set by the combinational paths from the input
// register through the decimal split into the digit store and from the digit store
// through the segment lookup into the result register. conversion_period (reset 25) is
// written through cfg_we_i / cfg_wdata_i only while the block is idle, a rule for the
// user that the block does not enforce; a period of zero or one requests a conversion on
// every tick. With DIGITS = 8 the last position has no select bit and an all-zero select.
module scanned_decimal_segment_display import scdd_pkg::*; #(
  parameter int unsigned DIGITS = DigitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PeriodW-1:0] cfg_wdata_i,
  scdd_in_if.sink            item_i,
  scdd_out_if.source         result_o
);

  // input register
  logic    in_valid_q;
  item_t   in_item_q;
  logic    take;
  dec_t    dec;
  result_t res;
  logic    out_valid;

  // accept whenever the input register is empty or drains this cycle
  assign item_i.ready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_item_q.cmd    <= item_i.cmd;
      in_item_q.sample <= item_i.sample;
    end
  end

  // decimal split of the held sample
  scdd_bcd u_bcd (
    .sample_i (in_item_q.sample),
    .dec_o    (dec)
  );

  // digit store, scan and pacing counters, result register
  scdd_core #(
    .DIGITS (DIGITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_q),
    .in_item_i   (in_item_q),
    .dec_i       (dec),
    .in_take_o   (take),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .out_res_o   (res)
  );

  assign result_o.valid            = out_valid;
  assign result_o.segments_n       = res.segments_n;
  assign result_o.digit_select     = res.digit_select;
  assign result_o.start_conversion = res.start_conversion;

  // at most one position enabled at a time
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> $onehot0(result_o.digit_select))
    else $error("digit select not one-hot");

  // decimal point never lit
  a_dp_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> result_o.segments_n[SegW-1])
    else $error("decimal point driven");

  // an accepted transfer is held in the input register next cycle
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> in_valid_q)
    else $error("accepted item lost");

  // a stalled result is never overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !result_o.ready) |-> !(take && (in_item_q.cmd == CmdTick)))
    else $error("result register overrun");

endmodule
